### hw/rtl/mi3_pkg.sv
// ============================================================================
// mi3_pkg
// Shared constants for the 3x3 matrix inverse pipeline.
// ============================================================================
`timescale 1ns / 1ps

package mi3_pkg;

    localparam int NUM_ELEMS = 9;
    localparam int THR_WIDTH = 31;
    localparam logic [THR_WIDTH-1:0] THR_RESET = 31'd7;

    typedef logic [3:0] elem_idx_t;

    // cofactor k = e[p]*e[q] - e[s]*e[t], row-major element indices
    localparam elem_idx_t COF_IDX [NUM_ELEMS][4] = '{
        '{4'd4, 4'd8, 4'd7, 4'd5}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd3, 4'd2, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd6, 4'd4}, '{4'd6, 4'd1, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd3, 4'd1}
    };

endpackage

### hw/rtl/mi3_cofactor.sv
// ============================================================================
// mi3_cofactor
// Two stages: pairwise element products, then the nine adjugate cofactors.
// ============================================================================
`timescale 1ns / 1ps

module mi3_cofactor #(
    parameter int ELEM_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [ELEM_WIDTH-1:0]  elem [mi3_pkg::NUM_ELEMS],
    output logic signed [2*ELEM_WIDTH:0]  cof  [mi3_pkg::NUM_ELEMS]
);
    import mi3_pkg::*;

    localparam int PW = 2 * ELEM_WIDTH;
    localparam int CW = 2 * ELEM_WIDTH + 1;

    logic signed [PW-1:0] prod_a_reg [NUM_ELEMS];
    logic signed [PW-1:0] prod_b_reg [NUM_ELEMS];
    logic signed [CW-1:0] cof_reg    [NUM_ELEMS];

    for (genvar k = 0; k < NUM_ELEMS; k++) begin : g_cof
        always_ff @(posedge aclk) begin
            if (en) begin
                prod_a_reg[k] <= elem[COF_IDX[k][0]] * elem[COF_IDX[k][1]];
                prod_b_reg[k] <= elem[COF_IDX[k][2]] * elem[COF_IDX[k][3]];
                cof_reg[k]    <= CW'(prod_a_reg[k]) - CW'(prod_b_reg[k]);
            end
        end
        assign cof[k] = cof_reg[k];
    end

endmodule

### hw/rtl/mi3_det.sv
// ============================================================================
// mi3_det
// Determinant by first-row expansion over split partial products, then
// magnitude, sign and the singular test against the threshold.
// ============================================================================
`timescale 1ns / 1ps

module mi3_det #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                           aclk,
    input  logic                           en,
    input  logic signed [ELEM_WIDTH-1:0]   row0 [3],
    input  logic signed [2*ELEM_WIDTH:0]   cof0 [3],
    input  logic [mi3_pkg::THR_WIDTH-1:0]  thr,
    output logic [3*ELEM_WIDTH:0]          det_mag,
    output logic                           det_neg,
    output logic                           singular
);
    import mi3_pkg::*;

    localparam int E    = ELEM_WIDTH;
    localparam int DW   = 3 * E + 2;
    localparam int CMPW = 3 * E + 2 * FRAC_BITS + THR_WIDTH;

    logic signed [2*E:0]  pp_lo_reg [3];
    logic signed [2*E:0]  pp_hi_reg [3];
    logic signed [DW-1:0] term_reg  [3];
    logic signed [DW-1:0] det_reg;
    logic [DW-1:0]        mag_next;
    logic                 sing_next;
    logic [DW-2:0]        det_mag_reg;
    logic                 det_neg_reg;
    logic                 singular_reg;

    for (genvar i = 0; i < 3; i++) begin : g_term
        always_ff @(posedge aclk) begin
            if (en) begin
                pp_lo_reg[i] <= row0[i] * $signed({1'b0, cof0[i][E-1:0]});
                pp_hi_reg[i] <= row0[i] * $signed(cof0[i][2*E:E]);
                term_reg[i]  <= (DW'(pp_hi_reg[i]) <<< E) + DW'(pp_lo_reg[i]);
            end
        end
    end

    always_comb begin
        mag_next  = det_reg[DW-1] ? -det_reg : det_reg;
        sing_next = (mag_next == '0)
                 || (CMPW'(mag_next) < (CMPW'(thr) << (2 * FRAC_BITS)));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            det_reg      <= term_reg[0] + term_reg[1] + term_reg[2];
            det_mag_reg  <= mag_next[DW-2:0];
            det_neg_reg  <= det_reg[DW-1];
            singular_reg <= sing_next;
        end
    end

    assign det_mag  = det_mag_reg;
    assign det_neg  = det_neg_reg;
    assign singular = singular_reg;

endmodule

### hw/rtl/mi3_div.sv
// ============================================================================
// mi3_div
// Pipelined restoring divider: round(cof * 2^(2F) / det), ties away from
// zero, saturated to the signed element range. One quotient bit per stage.
// ============================================================================
`timescale 1ns / 1ps

module mi3_div #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [2*ELEM_WIDTH:0]  cof,
    input  logic [3*ELEM_WIDTH:0]         det_mag,
    input  logic                          det_neg,
    output logic signed [ELEM_WIDTH-1:0]  quo
);
    localparam int E  = ELEM_WIDTH;
    localparam int CW = 2 * E + 1;
    localparam int MW = 3 * E + 1;
    localparam int DW = MW + 1;
    localparam int RW = DW + 1;
    localparam int NW = CW + 2 * FRAC_BITS + 2;
    localparam int XW = NW + DW;
    localparam int NS = E + 2;

    logic [CW-1:0] mag7_reg;
    logic [MW-1:0] dm7_reg;
    logic          neg7_reg;
    logic [NW-1:0] n8_reg;
    logic [DW-1:0] d28_reg;
    logic          neg8_reg;
    logic [XW-1:0] hi_x;

    logic [RW-1:0] rem_reg [NS];
    logic [E:0]    q_reg   [NS];
    logic [E:0]    low_reg [NS];
    logic [DW-1:0] d2_reg  [NS];
    logic          ovf_reg [NS];
    logic          neg_reg [NS];

    logic [E:0]    lim;
    logic [E:0]    sat;
    logic [E:0]    res_next;
    logic [E-1:0]  quo_reg;

    assign hi_x = XW'(n8_reg >> (E + 1));

    always_ff @(posedge aclk) begin
        if (en) begin
            mag7_reg   <= cof[CW-1] ? -cof : cof;
            dm7_reg    <= det_mag;
            neg7_reg   <= cof[CW-1] ^ det_neg;
            n8_reg     <= (NW'(mag7_reg) << (2 * FRAC_BITS + 1)) + NW'(dm7_reg);
            d28_reg    <= {dm7_reg, 1'b0};
            neg8_reg   <= neg7_reg;
            rem_reg[0] <= hi_x[RW-1:0];
            q_reg[0]   <= '0;
            low_reg[0] <= n8_reg[E:0];
            d2_reg[0]  <= d28_reg;
            ovf_reg[0] <= hi_x >= XW'(d28_reg);
            neg_reg[0] <= neg8_reg;
        end
    end

    for (genvar j = 0; j <= E; j++) begin : g_step
        logic [RW-1:0] trial;
        logic          ge;
        assign trial = {rem_reg[j][RW-2:0], low_reg[j][E-j]};
        assign ge    = trial >= RW'(d2_reg[j]);
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j+1] <= ge ? trial - RW'(d2_reg[j]) : trial;
                q_reg[j+1]   <= q_reg[j] | ((E+1)'(ge) << (E - j));
                low_reg[j+1] <= low_reg[j];
                d2_reg[j+1]  <= d2_reg[j];
                ovf_reg[j+1] <= ovf_reg[j];
                neg_reg[j+1] <= neg_reg[j];
            end
        end
    end

    always_comb begin
        lim = (E+1)'(1) << (E - 1);
        if (!neg_reg[NS-1]) begin
            lim = lim - (E+1)'(1);
        end
        sat      = (ovf_reg[NS-1] || (q_reg[NS-1] > lim)) ? lim : q_reg[NS-1];
        res_next = neg_reg[NS-1] ? -sat : sat;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg <= res_next[E-1:0];
        end
    end

    assign quo = quo_reg;

endmodule

### hw/rtl/matrix3x3_inverse_unit.sv
// ============================================================================
// matrix3x3_inverse_unit
// Throughput: one matrix per cycle unless a waiting result is held by a low m_ready;
// depth is set by the one-bit-per-stage divider.
// Reset: synchronous active-low aresetn clears valid bits, threshold reads 7.
// Datapath registers are not reset.
// ============================================================================
`timescale 1ns / 1ps

module matrix3x3_inverse_unit #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mi3_pkg::THR_WIDTH-1:0]       cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [ELEM_WIDTH-1:0]        s_in_r0c0,
    input  logic signed [ELEM_WIDTH-1:0]        s_in_r0c1,
    input  logic signed [ELEM_WIDTH-1:0]        s_in_r0c2,
    input  logic signed [ELEM_WIDTH-1:0]        s_in_r1c0,
    input  logic signed [ELEM_WIDTH-1:0]        s_in_r1c1,
    input  logic signed [ELEM_WIDTH-1:0]        s_in_r1c2,
    input  logic signed [ELEM_WIDTH-1:0]        s_in_r2c0,
    input  logic signed [ELEM_WIDTH-1:0]        s_in_r2c1,
    input  logic signed [ELEM_WIDTH-1:0]        s_in_r2c2,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [ELEM_WIDTH-1:0]        m_out_r0c0,
    output logic signed [ELEM_WIDTH-1:0]        m_out_r0c1,
    output logic signed [ELEM_WIDTH-1:0]        m_out_r0c2,
    output logic signed [ELEM_WIDTH-1:0]        m_out_r1c0,
    output logic signed [ELEM_WIDTH-1:0]        m_out_r1c1,
    output logic signed [ELEM_WIDTH-1:0]        m_out_r1c2,
    output logic signed [ELEM_WIDTH-1:0]        m_out_r2c0,
    output logic signed [ELEM_WIDTH-1:0]        m_out_r2c1,
    output logic signed [ELEM_WIDTH-1:0]        m_out_r2c2,
    output logic                                m_singular
);
    import mi3_pkg::*;

    localparam int E   = ELEM_WIDTH;
    localparam int LAT = E + 12;
    localparam int EPD = E + 11;
    localparam int SPD = E + 5;
    localparam int CPD = 4;

    logic                 pipe_en;
    logic [THR_WIDTH-1:0] thr_reg;
    logic [LAT-1:0]       vld_reg;

    logic signed [E-1:0]  in_elem   [NUM_ELEMS];
    logic signed [E-1:0]  elem_reg  [EPD][NUM_ELEMS];
    logic signed [2*E:0]  cof_w     [NUM_ELEMS];
    logic signed [2*E:0]  cof_reg   [CPD][NUM_ELEMS];
    logic signed [E-1:0]  row0      [3];
    logic signed [2*E:0]  cof0      [3];
    logic [3*E:0]         det_mag;
    logic                 det_neg;
    logic                 det_sing;
    logic [SPD-1:0]       sing_reg;
    logic signed [E-1:0]  quo       [NUM_ELEMS];
    logic signed [E-1:0]  out_reg   [NUM_ELEMS];
    logic                 out_sing_reg;

    assign pipe_en   = !vld_reg[LAT-1] || m_ready;
    assign s_ready   = pipe_en && aresetn;
    assign cfg_ready = aresetn;
    assign m_valid   = vld_reg[LAT-1];

    assign in_elem[0] = s_in_r0c0;
    assign in_elem[1] = s_in_r0c1;
    assign in_elem[2] = s_in_r0c2;
    assign in_elem[3] = s_in_r1c0;
    assign in_elem[4] = s_in_r1c1;
    assign in_elem[5] = s_in_r1c2;
    assign in_elem[6] = s_in_r2c0;
    assign in_elem[7] = s_in_r2c1;
    assign in_elem[8] = s_in_r2c2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
            vld_reg <= '0;
        end else begin
            if (cfg_valid) begin
                thr_reg <= cfg_data;
            end
            if (pipe_en) begin
                vld_reg <= {vld_reg[LAT-2:0], s_valid};
            end
        end
    end

    // element, cofactor and singular-flag shift lines for the pass-through path, the det row and the dividers
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            elem_reg[0] <= in_elem;
            for (int i = 1; i < EPD; i++) begin
                elem_reg[i] <= elem_reg[i-1];
            end
            cof_reg[0] <= cof_w;
            for (int i = 1; i < CPD; i++) begin
                cof_reg[i] <= cof_reg[i-1];
            end
            sing_reg <= {sing_reg[SPD-2:0], det_sing};
        end
    end

    mi3_cofactor #(
        .ELEM_WIDTH (E)
    ) u_cofactor (
        .aclk (aclk),
        .en   (pipe_en),
        .elem (in_elem),
        .cof  (cof_w)
    );

    assign row0[0] = elem_reg[1][0];
    assign row0[1] = elem_reg[1][1];
    assign row0[2] = elem_reg[1][2];
    assign cof0[0] = cof_w[0];
    assign cof0[1] = cof_w[3];
    assign cof0[2] = cof_w[6];

    mi3_det #(
        .ELEM_WIDTH (E),
        .FRAC_BITS  (FRAC_BITS)
    ) u_det (
        .aclk     (aclk),
        .en       (pipe_en),
        .row0     (row0),
        .cof0     (cof0),
        .thr      (thr_reg),
        .det_mag  (det_mag),
        .det_neg  (det_neg),
        .singular (det_sing)
    );

    for (genvar k = 0; k < NUM_ELEMS; k++) begin : g_div
        mi3_div #(
            .ELEM_WIDTH (E),
            .FRAC_BITS  (FRAC_BITS)
        ) u_div (
            .aclk    (aclk),
            .en      (pipe_en),
            .cof     (cof_reg[CPD-1][k]),
            .det_mag (det_mag),
            .det_neg (det_neg),
            .quo     (quo[k])
        );

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                out_reg[k] <= sing_reg[SPD-1] ? elem_reg[EPD-1][k] : quo[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            out_sing_reg <= sing_reg[SPD-1];
        end
    end

    assign m_out_r0c0 = out_reg[0];
    assign m_out_r0c1 = out_reg[1];
    assign m_out_r0c2 = out_reg[2];
    assign m_out_r1c0 = out_reg[3];
    assign m_out_r1c1 = out_reg[4];
    assign m_out_r1c2 = out_reg[5];
    assign m_out_r2c0 = out_reg[6];
    assign m_out_r2c1 = out_reg[7];
    assign m_out_r2c2 = out_reg[8];
    assign m_singular = out_sing_reg;

`ifndef SYNTHESIS
    // a stalled pipeline neither gains nor drops requests
    assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && !pipe_en) |=> $stable(vld_reg))
        else $error("valid bits moved during stall");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && cfg_valid) |=> (thr_reg == $past(cfg_data)))
        else $error("threshold write lost");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && pipe_en) |=> (vld_reg[0] == $past(s_valid)))
        else $error("input request not captured");
`endif

endmodule

### tb/sv/matrix3x3_inverse_checker.sv
// ============================================================================
// matrix3x3_inverse_checker
// Watches the matrix request, result and threshold channels of the inverse
// unit. Predicts each result from the accepted matrix with exact wide integer
// arithmetic and compares it field by field with the result that comes out.
// ============================================================================
`timescale 1ns / 1ps

module matrix3x3_inverse_checker (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [30:0]      cfg_data,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic [8:0][31:0] s_mat,
    input  logic             m_valid,
    input  logic             m_ready,
    input  logic [8:0][31:0] m_mat,
    input  logic             m_singular,
    output int               n_errors,
    output int               n_pending
);

    typedef struct packed {
        logic [8:0][31:0] elem;
        logic             singular;
    } inverse_t;

    inverse_t    inverse_q[$];
    logic [30:0] threshold;

    // cofactor k = e[a]*e[b] - e[c]*e[d]
    localparam int COF [9][4] = '{
        '{4, 8, 7, 5}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{3, 2, 0, 5},
        '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
    };

    function automatic inverse_t invert_matrix(logic [8:0][31:0] m, logic [30:0] thr);
        logic signed [127:0] e [9];
        logic signed [127:0] det;
        logic signed [127:0] cof;
        logic [127:0]        det_mag;
        logic [127:0]        cof_mag;
        logic [127:0]        quo;
        logic [127:0]        lim;
        logic                neg;
        inverse_t            r;
        for (int k = 0; k < 9; k++) begin
            e[k] = {{96{m[k][31]}}, m[k]};
        end
        det = e[0]*e[4]*e[8] + e[1]*e[5]*e[6] + e[2]*e[3]*e[7]
            - e[0]*e[5]*e[7] - e[1]*e[3]*e[8] - e[2]*e[4]*e[6];
        det_mag = det[127] ? -det : det;
        if (det_mag == 0 || det_mag < ({97'd0, thr} << 32)) begin
            r.elem = m;
            r.singular = 1'b1;
            return r;
        end
        for (int k = 0; k < 9; k++) begin
            cof = e[COF[k][0]]*e[COF[k][1]] - e[COF[k][2]]*e[COF[k][3]];
            cof_mag = cof[127] ? -cof : cof;
            neg = cof[127] ^ det[127];
            // round half away from zero: (2c*2^F*2^F + d) / 2d
            quo = ((cof_mag << 33) + det_mag) / (det_mag << 1);
            lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
            if (quo > lim) begin
                quo = lim;
            end
            r.elem[k] = neg ? -quo[31:0] : quo[31:0];
        end
        r.singular = 1'b0;
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch %s: got %h, want %h", $time, what, got, want);
        n_errors++;
    endtask

    initial begin
        n_errors = 0;
        n_pending = 0;
        threshold = 31'd7;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            threshold <= 31'd7;
        end else begin
            if (cfg_valid && cfg_ready) begin
                threshold <= cfg_data;
            end
            if (s_valid && s_ready) begin
                inverse_q.push_back(invert_matrix(s_mat, threshold));
            end
            if (m_valid && m_ready) begin
                if (inverse_q.size() == 0) begin
                    report("unexpected result", m_mat[0], 32'h0);
                end else begin
                    inverse_t want;
                    want = inverse_q.pop_front();
                    for (int k = 0; k < 9; k++) begin
                        if (m_mat[k] !== want.elem[k]) begin
                            report($sformatf("r%0dc%0d", k / 3, k % 3), m_mat[k], want.elem[k]);
                        end
                    end
                    if (m_singular !== want.singular) begin
                        report("singular", {31'd0, m_singular}, {31'd0, want.singular});
                    end
                end
            end
            n_pending <= inverse_q.size();
        end
    end

endmodule

### tb/sv/tb.sv
// ============================================================================
// tb
// Stimulus and verdict for matrix3x3_inverse_unit: directed and random 3x3
// Q16.16 matrices over several singular thresholds, with random gaps and
// stalls on both channels; the checker predicts and compares the results.
// ============================================================================
`timescale 1ns / 1ps

module tb;

    localparam int ONE = 65536;
    localparam int WATCHDOG_LIMIT = 5000;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [30:0]      cfg_data = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [8:0][31:0] s_mat = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [8:0][31:0] m_mat;
    logic             m_singular;
    int               n_errors;
    int               n_pending;
    int               idle_cycles = 0;
    logic             long_hold = 1'b0;

    matrix3x3_inverse_unit i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_r0c0  (s_mat[0]),
        .s_in_r0c1  (s_mat[1]),
        .s_in_r0c2  (s_mat[2]),
        .s_in_r1c0  (s_mat[3]),
        .s_in_r1c1  (s_mat[4]),
        .s_in_r1c2  (s_mat[5]),
        .s_in_r2c0  (s_mat[6]),
        .s_in_r2c1  (s_mat[7]),
        .s_in_r2c2  (s_mat[8]),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_r0c0 (m_mat[0]),
        .m_out_r0c1 (m_mat[1]),
        .m_out_r0c2 (m_mat[2]),
        .m_out_r1c0 (m_mat[3]),
        .m_out_r1c1 (m_mat[4]),
        .m_out_r1c2 (m_mat[5]),
        .m_out_r2c0 (m_mat[6]),
        .m_out_r2c1 (m_mat[7]),
        .m_out_r2c2 (m_mat[8]),
        .m_singular (m_singular)
    );

    matrix3x3_inverse_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_mat      (s_mat),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_mat      (m_mat),
        .m_singular (m_singular),
        .n_errors   (n_errors),
        .n_pending  (n_pending)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(15, 80);
    endfunction

    // result side: random ready, occasional long stalls, one forced hold-off
    initial begin
        int p;
        forever begin
            @(posedge aclk);
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                long_hold = 1'b0;
            end else begin
                p = $urandom_range(0, 99);
                if (p < 2) begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(15, 80)) @(posedge aclk);
                end else begin
                    m_ready <= (p < 75);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
                || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_matrix(logic [8:0][31:0] m);
        int g;
        s_valid <= 1'b1;
        s_mat   <= m;
        do @(posedge aclk); while (!s_ready);
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_threshold(logic [30:0] thr);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= thr;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [8:0][31:0] diag(int a, int b, int c);
        logic [8:0][31:0] m;
        m = '0;
        m[0] = a;
        m[4] = b;
        m[8] = c;
        return m;
    endfunction

    function automatic logic [8:0][31:0] random_matrix();
        logic [8:0][31:0] m;
        int kind;
        int span;
        kind = $urandom_range(0, 9);
        span = ($urandom_range(0, 3) == 0) ? 255 : 4 * ONE;
        for (int k = 0; k < 9; k++) begin
            case (kind)
                0, 1: begin
                    m[k] = $urandom();
                end
                2, 3, 4, 5: begin
                    m[k] = $urandom_range(0, 2 * span) - span;
                end
                default: begin
                    m[k] = $urandom_range(0, ONE / 2) - ONE / 4 + ((k % 4 == 0) ? ONE : 0);
                end
            endcase
        end
        // dependent rows give an exact zero determinant
        if (kind == 5 || kind == 9) begin
            for (int k = 0; k < 3; k++) begin
                m[6 + k] = m[k] + m[3 + k];
            end
        end
        return m;
    endfunction

    initial begin
        logic [30:0] thr_list [5];
        thr_list = '{31'd0, 31'h7fff_ffff, 31'd65536, 31'd1, 31'd7};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_matrix(diag(ONE, ONE, ONE));
        send_matrix('0);
        send_matrix({9{32'h7fff_ffff}});
        send_matrix({9{32'h8000_0000}});
        send_matrix({9{32'hffff_ffff}});
        send_matrix(diag(1, 1, 1));
        send_matrix(diag(-1, 1, 1));
        send_matrix(diag(7, ONE, ONE));
        send_matrix(diag(6, ONE, ONE));
        send_matrix(diag(-7, ONE, ONE));
        send_matrix(diag(2 * ONE, 4 * ONE, -8 * ONE));
        send_matrix(diag(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        send_matrix(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_matrix(diag(3 * ONE, 3 * ONE, 3 * ONE));
        send_matrix({32'h8000_0000, 32'h7fff_ffff, 32'd1, 32'hffff_ffff, 32'd0,
                     32'h5555_5555, 32'haaaa_aaaa, 32'd2, 32'h0001_0000});
        send_matrix({32'd0, 32'd0, 32'd65536, 32'd0, 32'd65536, 32'd0,
                     32'd65536, 32'd0, 32'd0});

        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin
                long_hold = 1'b1;
            end
            for (int i = 0; i < 290; i++) begin
                send_matrix(random_matrix());
            end
            if (ph < 5) begin
                write_threshold(ph == 4 ? 31'($urandom()) : thr_list[ph]);
            end
        end

        wait_drained();
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### matrix3x3_inverse_unit.f
hw/rtl/mi3_pkg.sv
hw/rtl/mi3_cofactor.sv
hw/rtl/mi3_det.sv
hw/rtl/mi3_div.sv
hw/rtl/matrix3x3_inverse_unit.sv
tb/sv/matrix3x3_inverse_checker.sv
tb/sv/tb.sv
